// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the tilt angle rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TILT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TILT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tilt_pkg.sv -----
// shared widths, constants, control struct and arctangent table for the tilt angle unit
package tilt_pkg;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 15;
  localparam int FRAC_BITS   = 16;
  localparam int ANGLE_FRAC  = 16;
  localparam int DW          = 36;
  localparam int MAG_W       = 33;
  localparam int AW          = 32;
  localparam int ABS_W       = IN_W + 1;
  localparam int GAIN_W      = 30;
  localparam int LO_W        = 16;
  localparam int HI_W        = MAG_W - LO_W;
  localparam int PL_W        = LO_W + GAIN_W;
  localparam int PH_W        = HI_W + GAIN_W;
  localparam int SUM_W       = PH_W + LO_W;
  localparam int TABLE_LEN   = 24;
  localparam int ANGLE_LIMIT = 9000;

  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032875;
  localparam logic [SUM_W-1:0]  GAIN_RND     = SUM_W'(1) << (GAIN_W - 1);

  typedef struct packed {
    logic vld;
    logic x_zero;
  } tilt_ctl_t;

  function automatic logic signed [AW-1:0] atan_entry(input int idx);
    logic signed [AW-1:0] val;
    begin
      case (idx)
        0:       val = 32'sd294912000;
        1:       val = 32'sd174096719;
        2:       val = 32'sd91987925;
        3:       val = 32'sd46694507;
        4:       val = 32'sd23437865;
        5:       val = 32'sd11730358;
        6:       val = 32'sd5866610;
        7:       val = 32'sd2933484;
        8:       val = 32'sd1466764;
        9:       val = 32'sd733385;
        10:      val = 32'sd366693;
        11:      val = 32'sd183346;
        12:      val = 32'sd91673;
        13:      val = 32'sd45837;
        14:      val = 32'sd22918;
        15:      val = 32'sd11459;
        16:      val = 32'sd5730;
        17:      val = 32'sd2865;
        18:      val = 32'sd1432;
        19:      val = 32'sd716;
        20:      val = 32'sd358;
        21:      val = 32'sd179;
        22:      val = 32'sd90;
        23:      val = 32'sd45;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

endpackage

// ----- hw/rtl/tilt_angle_from_accel_unit.sv -----
// start to out_valid: input reg, magnitude stages, gain multiply, angle stages, output reg
// one sample per cycle, busy stays low; each mag/angle stage is one cordic micro-rotation
// the magnitude gain correction registers two partial products, then their rounded sum
// results are strobed for one cycle on out_valid; the receiver cannot stall
// synchronous active-low reset clears all valid bits; data registers are not reset
`include "assert_macros.svh"

module tilt_angle_from_accel_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tilt_pkg::IN_W-1:0]    in_accel_x,
  input  logic signed [tilt_pkg::IN_W-1:0]    in_accel_y,
  input  logic signed [tilt_pkg::IN_W-1:0]    in_accel_z,
  output logic                                out_valid,
  output logic signed [tilt_pkg::OUT_W-1:0]   out_angle_centideg
);

  localparam int LAT = 2 * CORDIC_STEPS + 4;
  localparam int PAD = tilt_pkg::DW - tilt_pkg::ABS_W - tilt_pkg::FRAC_BITS;
  localparam int RND_W = tilt_pkg::AW - tilt_pkg::ANGLE_FRAC;

  tilt_pkg::tilt_ctl_t                in_ctl_nxt;
  logic signed [tilt_pkg::ABS_W-1:0]  y_ext, z_ext;
  logic [tilt_pkg::ABS_W-1:0]         y_abs, z_abs;

  tilt_pkg::tilt_ctl_t                mctl [0:CORDIC_STEPS];
  logic signed [tilt_pkg::DW-1:0]     ma   [0:CORDIC_STEPS];
  logic signed [tilt_pkg::DW-1:0]     mb   [0:CORDIC_STEPS];
  logic signed [tilt_pkg::IN_W-1:0]   mx   [0:CORDIC_STEPS];

  tilt_pkg::tilt_ctl_t                gctl;
  logic [tilt_pkg::MAG_W-1:0]         g_r_mag;
  logic signed [tilt_pkg::IN_W-1:0]   gx;

  tilt_pkg::tilt_ctl_t                actl [0:CORDIC_STEPS];
  logic signed [tilt_pkg::DW-1:0]     au   [0:CORDIC_STEPS];
  logic signed [tilt_pkg::DW-1:0]     av   [0:CORDIC_STEPS];
  logic signed [tilt_pkg::AW-1:0]     aang [0:CORDIC_STEPS];

  tilt_pkg::tilt_ctl_t                ictl_r;
  logic signed [tilt_pkg::DW-1:0]     ia_r, ib_r;
  logic signed [tilt_pkg::IN_W-1:0]   ix_r;

  logic signed [tilt_pkg::AW-1:0]     ang_fin;
  logic [tilt_pkg::AW-1:0]            ang_mag;
  logic [tilt_pkg::AW-1:0]            ang_rnd;
  logic [RND_W-1:0]                   deg_mag;
  logic [tilt_pkg::OUT_W-1:0]         deg_sat;
  logic signed [tilt_pkg::OUT_W-1:0]  res_nxt;
  logic                               vld_r;
  logic signed [tilt_pkg::OUT_W-1:0]  res_r;

  assign busy = 1'b0;

  always_comb begin
    in_ctl_nxt.vld    = start && !busy;
    in_ctl_nxt.x_zero = (in_accel_x == '0);
    y_ext = {in_accel_y[tilt_pkg::IN_W-1], in_accel_y};
    z_ext = {in_accel_z[tilt_pkg::IN_W-1], in_accel_z};
    y_abs = y_ext[tilt_pkg::ABS_W-1] ? tilt_pkg::ABS_W'(-y_ext) : tilt_pkg::ABS_W'(y_ext);
    z_abs = z_ext[tilt_pkg::ABS_W-1] ? tilt_pkg::ABS_W'(-z_ext) : tilt_pkg::ABS_W'(z_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ictl_r <= '0;
    end else begin
      ictl_r <= in_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia_r <= {{PAD{1'b0}}, y_abs, {tilt_pkg::FRAC_BITS{1'b0}}};
    ib_r <= {{PAD{1'b0}}, z_abs, {tilt_pkg::FRAC_BITS{1'b0}}};
    ix_r <= in_accel_x;
  end

  assign mctl[0] = ictl_r;
  assign ma[0]   = ia_r;
  assign mb[0]   = ib_r;
  assign mx[0]   = ix_r;

  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_mag
    tilt_mag_stage #(
      .SHIFT (gi)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (mctl[gi]),
      .a_i   (ma[gi]),
      .b_i   (mb[gi]),
      .x_i   (mx[gi]),
      .ctl_o (mctl[gi+1]),
      .a_o   (ma[gi+1]),
      .b_o   (mb[gi+1]),
      .x_o   (mx[gi+1])
    );
  end

  tilt_gain_mul u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (mctl[CORDIC_STEPS]),
    .mag_i (ma[CORDIC_STEPS][tilt_pkg::MAG_W-1:0]),
    .x_i   (mx[CORDIC_STEPS]),
    .ctl_o (gctl),
    .r_o   (g_r_mag),
    .x_o   (gx)
  );

  assign actl[0] = gctl;
  assign au[0]   = {{(tilt_pkg::DW-tilt_pkg::MAG_W){1'b0}}, g_r_mag};
  assign av[0]   = {{(tilt_pkg::DW-tilt_pkg::IN_W-tilt_pkg::FRAC_BITS){gx[tilt_pkg::IN_W-1]}},
                    gx, {tilt_pkg::FRAC_BITS{1'b0}}};
  assign aang[0] = '0;

  for (genvar gj = 0; gj < CORDIC_STEPS; gj++) begin : g_ang
    tilt_ang_stage #(
      .SHIFT (gj)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (actl[gj]),
      .u_i   (au[gj]),
      .v_i   (av[gj]),
      .ang_i (aang[gj]),
      .ctl_o (actl[gj+1]),
      .u_o   (au[gj+1]),
      .v_o   (av[gj+1]),
      .ang_o (aang[gj+1])
    );
  end

  always_comb begin
    ang_fin = aang[CORDIC_STEPS];
    ang_mag = ang_fin[tilt_pkg::AW-1] ? tilt_pkg::AW'(-ang_fin) : tilt_pkg::AW'(ang_fin);
    ang_rnd = ang_mag + (tilt_pkg::AW'(1) << (tilt_pkg::ANGLE_FRAC - 1));
    deg_mag = ang_rnd[tilt_pkg::AW-1:tilt_pkg::ANGLE_FRAC];
    if (deg_mag > RND_W'(tilt_pkg::ANGLE_LIMIT)) begin
      deg_sat = tilt_pkg::OUT_W'(tilt_pkg::ANGLE_LIMIT);
    end else begin
      deg_sat = deg_mag[tilt_pkg::OUT_W-1:0];
    end
    if (actl[CORDIC_STEPS].x_zero) begin
      res_nxt = '0;
    end else if (ang_fin[tilt_pkg::AW-1]) begin
      res_nxt = -$signed(deg_sat);
    end else begin
      res_nxt = $signed(deg_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= actl[CORDIC_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid          = vld_r;
  assign out_angle_centideg = res_r;

  `TILT_ASSERT_SAME(out_needs_start, clk, rst_n, out_valid, $past(start, LAT), "result strobe without a matching start")
  `TILT_ASSERT_SAME(out_in_range, clk, rst_n, out_valid, (out_angle_centideg <= 15'sd9000) && (out_angle_centideg >= -15'sd9000), "angle outside +-90 degrees")
  `TILT_ASSERT_NEXT(zero_x_gives_zero, clk, rst_n, actl[CORDIC_STEPS].vld && actl[CORDIC_STEPS].x_zero, out_angle_centideg == '0, "zero x sample gave a nonzero angle")

endmodule

// ----- hw/rtl/tilt_mag_stage.sv -----
// one registered cordic vectoring micro-rotation of the magnitude pass
`include "assert_macros.svh"

module tilt_mag_stage #(
  parameter int SHIFT = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tilt_pkg::tilt_ctl_t                ctl_i,
  input  logic signed [tilt_pkg::DW-1:0]     a_i,
  input  logic signed [tilt_pkg::DW-1:0]     b_i,
  input  logic signed [tilt_pkg::IN_W-1:0]   x_i,
  output tilt_pkg::tilt_ctl_t                ctl_o,
  output logic signed [tilt_pkg::DW-1:0]     a_o,
  output logic signed [tilt_pkg::DW-1:0]     b_o,
  output logic signed [tilt_pkg::IN_W-1:0]   x_o
);

  tilt_pkg::tilt_ctl_t                 ctl_r;
  logic signed [tilt_pkg::DW-1:0]      a_r, a_nxt;
  logic signed [tilt_pkg::DW-1:0]      b_r, b_nxt;
  logic signed [tilt_pkg::IN_W-1:0]    x_r;

  always_comb begin
    if (!b_i[tilt_pkg::DW-1]) begin
      a_nxt = a_i + (b_i >>> SHIFT);
      b_nxt = b_i - (a_i >>> SHIFT);
    end else begin
      a_nxt = a_i - (b_i >>> SHIFT);
      b_nxt = b_i + (a_i >>> SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    x_r <= x_i;
  end

  assign ctl_o = ctl_r;
  assign a_o   = a_r;
  assign b_o   = b_r;
  assign x_o   = x_r;

  `TILT_ASSERT_NEXT(a_stays_nonneg, clk, rst_n, ctl_i.vld && !a_i[tilt_pkg::DW-1], !a_r[tilt_pkg::DW-1], "magnitude accumulator went negative")

endmodule

// ----- hw/rtl/tilt_gain_mul.sv -----
// two-stage multiply of the magnitude by the inverse cordic gain with rounding
module tilt_gain_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tilt_pkg::tilt_ctl_t                 ctl_i,
  input  logic [tilt_pkg::MAG_W-1:0]          mag_i,
  input  logic signed [tilt_pkg::IN_W-1:0]    x_i,
  output tilt_pkg::tilt_ctl_t                 ctl_o,
  output logic [tilt_pkg::MAG_W-1:0]          r_o,
  output logic signed [tilt_pkg::IN_W-1:0]    x_o
);

  tilt_pkg::tilt_ctl_t                 ctl1_r, ctl2_r;
  logic [tilt_pkg::PL_W-1:0]           pl_r, pl_nxt;
  logic [tilt_pkg::PH_W-1:0]           ph_r, ph_nxt;
  logic signed [tilt_pkg::IN_W-1:0]    x1_r, x2_r;
  logic [tilt_pkg::SUM_W-1:0]          sum_nxt;
  logic [tilt_pkg::MAG_W-1:0]          r_r;

  always_comb begin
    pl_nxt  = tilt_pkg::PL_W'(mag_i[tilt_pkg::LO_W-1:0]) * tilt_pkg::PL_W'(tilt_pkg::INV_GAIN_Q30);
    ph_nxt  = tilt_pkg::PH_W'(mag_i[tilt_pkg::MAG_W-1:tilt_pkg::LO_W])
              * tilt_pkg::PH_W'(tilt_pkg::INV_GAIN_Q30);
    sum_nxt = {ph_r, {tilt_pkg::LO_W{1'b0}}} + tilt_pkg::SUM_W'(pl_r) + tilt_pkg::GAIN_RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    pl_r <= pl_nxt;
    ph_r <= ph_nxt;
    x1_r <= x_i;
    r_r  <= sum_nxt[tilt_pkg::GAIN_W +: tilt_pkg::MAG_W];
    x2_r <= x1_r;
  end

  assign ctl_o = ctl2_r;
  assign r_o   = r_r;
  assign x_o   = x2_r;

endmodule

// ----- hw/rtl/tilt_ang_stage.sv -----
// one registered cordic vectoring micro-rotation of the angle pass
module tilt_ang_stage #(
  parameter int SHIFT = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tilt_pkg::tilt_ctl_t              ctl_i,
  input  logic signed [tilt_pkg::DW-1:0]   u_i,
  input  logic signed [tilt_pkg::DW-1:0]   v_i,
  input  logic signed [tilt_pkg::AW-1:0]   ang_i,
  output tilt_pkg::tilt_ctl_t              ctl_o,
  output logic signed [tilt_pkg::DW-1:0]   u_o,
  output logic signed [tilt_pkg::DW-1:0]   v_o,
  output logic signed [tilt_pkg::AW-1:0]   ang_o
);

  localparam logic signed [tilt_pkg::AW-1:0] ATAN_STEP = tilt_pkg::atan_entry(SHIFT);

  tilt_pkg::tilt_ctl_t                ctl_r;
  logic signed [tilt_pkg::DW-1:0]     u_r, u_nxt;
  logic signed [tilt_pkg::DW-1:0]     v_r, v_nxt;
  logic signed [tilt_pkg::AW-1:0]     ang_r, ang_nxt;

  always_comb begin
    if (!v_i[tilt_pkg::DW-1]) begin
      u_nxt   = u_i + (v_i >>> SHIFT);
      v_nxt   = v_i - (u_i >>> SHIFT);
      ang_nxt = ang_i + ATAN_STEP;
    end else begin
      u_nxt   = u_i - (v_i >>> SHIFT);
      v_nxt   = v_i + (u_i >>> SHIFT);
      ang_nxt = ang_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    ang_r <= ang_nxt;
  end

  assign ctl_o = ctl_r;
  assign u_o   = u_r;
  assign v_o   = v_r;
  assign ang_o = ang_r;

endmodule
